// File: src/fmbi_pkg.sv
`timescale 1ns / 1ps

package fmbi_pkg;

    localparam int TABLE_DIM   = 16;
    localparam int IDX_W       = 4;
    localparam int ENTRY_W     = 16;
    localparam int RPM_W       = 14;
    localparam int PRS_W       = 11;
    localparam int OUT_W       = 16;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_WRITE  = 1'b1;

    localparam int BRK_N       = TABLE_DIM - 2;
    localparam int SEG_N       = TABLE_DIM - 1;

    localparam int BANK_N      = 4;
    localparam int BANK_DEPTH  = TABLE_DIM * TABLE_DIM / BANK_N;

    localparam int FRAC_BITS   = 16;
    localparam int RECIP_SHIFT = 39;
    localparam int Q_SHIFT     = RECIP_SHIFT - FRAC_BITS;
    localparam int Q_W         = 21;
    localparam int FRAC_W      = Q_W + 1;
    localparam int XU_W        = RPM_W;
    localparam int YU_W        = 11;
    localparam int SPD_RECIP_W = 31;
    localparam int PRS_RECIP_W = 34;
    localparam int XPROD_W     = XU_W + SPD_RECIP_W;
    localparam int YPROD_W     = YU_W + PRS_RECIP_W;
    localparam int DIFF_W      = ENTRY_W + 1;
    localparam int ACC_W       = FRAC_W + ENTRY_W + 2;
    localparam int LO_W        = ACC_W / 2;
    localparam int HI_W        = ACC_W - LO_W;
    localparam int SUM_W       = ACC_W + FRAC_W + 2;
    localparam int RND_W       = SUM_W - 2 * FRAC_BITS;

    localparam int PIPE_DEPTH  = 8;

    localparam logic [63:0] RCP_ONE = 64'd1 << RECIP_SHIFT;
    localparam logic [SPD_RECIP_W-1:0] RCP_300 = SPD_RECIP_W'((RCP_ONE + 64'd299) / 64'd300);
    localparam logic [SPD_RECIP_W-1:0] RCP_400 = SPD_RECIP_W'((RCP_ONE + 64'd399) / 64'd400);
    localparam logic [SPD_RECIP_W-1:0] RCP_500 = SPD_RECIP_W'((RCP_ONE + 64'd499) / 64'd500);
    localparam logic [PRS_RECIP_W-1:0] RCP_70  = PRS_RECIP_W'((RCP_ONE + 64'd69) / 64'd70);
    localparam logic [PRS_RECIP_W-1:0] RCP_50  = PRS_RECIP_W'((RCP_ONE + 64'd49) / 64'd50);
    localparam logic [PRS_RECIP_W-1:0] RCP_40  = PRS_RECIP_W'((RCP_ONE + 64'd39) / 64'd40);

    localparam logic [RPM_W-1:0] SPD_BRK [0:BRK_N-1] = '{
        14'd800,  14'd1200, 14'd1600, 14'd2000, 14'd2500, 14'd3000, 14'd3500,
        14'd4000, 14'd4500, 14'd5000, 14'd5500, 14'd6000, 14'd6500, 14'd7000
    };

    localparam logic signed [PRS_W-1:0] PRS_BRK [0:BRK_N-1] = '{
        -11'sd70,  -11'sd140, -11'sd210, -11'sd280, -11'sd350, -11'sd420, -11'sd490,
        -11'sd560, -11'sd630, -11'sd700, -11'sd770, -11'sd840, -11'sd910, -11'sd960
    };

    // The first segment on each axis is shifted up by whole segment widths so that the
    // numerator of the fraction never goes negative; the shift is taken back afterwards.
    localparam logic signed [15:0] SPD_BASE [0:SEG_N-1] = '{
        -16'sd100, 16'sd800,  16'sd1200, 16'sd1600, 16'sd2000,
        16'sd2500, 16'sd3000, 16'sd3500, 16'sd4000, 16'sd4500,
        16'sd5000, 16'sd5500, 16'sd6000, 16'sd6500, 16'sd7000
    };

    localparam logic signed [12:0] PRS_BASE [0:SEG_N-1] = '{
        13'sd1050,  -13'sd70,  -13'sd140, -13'sd210, -13'sd280,
        -13'sd350,  -13'sd420, -13'sd490, -13'sd560, -13'sd630,
        -13'sd700,  -13'sd770, -13'sd840, -13'sd910, -13'sd960
    };

    localparam logic [SPD_RECIP_W-1:0] SPD_RECIP [0:SEG_N-1] = '{
        RCP_300, RCP_400, RCP_400, RCP_400, RCP_500,
        RCP_500, RCP_500, RCP_500, RCP_500, RCP_500,
        RCP_500, RCP_500, RCP_500, RCP_500, RCP_500
    };

    localparam logic [PRS_RECIP_W-1:0] PRS_RECIP [0:SEG_N-1] = '{
        RCP_70, RCP_70, RCP_70, RCP_70, RCP_70,
        RCP_70, RCP_70, RCP_70, RCP_70, RCP_70,
        RCP_70, RCP_70, RCP_70, RCP_50, RCP_40
    };

    localparam logic signed [FRAC_W-1:0] SPD_SEG0_OFS = FRAC_W'(2 << FRAC_BITS);
    localparam logic signed [FRAC_W-1:0] PRS_SEG0_OFS = FRAC_W'(15 << FRAC_BITS);

    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   col;
        logic [ENTRY_W-1:0] value;
    } wr_req_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } rd_req_t;

    typedef struct packed {
        logic [ENTRY_W-1:0] t00;
        logic [ENTRY_W-1:0] t10;
        logic [ENTRY_W-1:0] t01;
        logic [ENTRY_W-1:0] t11;
    } corners_t;

endpackage

// File: src/fmbi_in_if.sv
`timescale 1ns / 1ps

interface fmbi_in_if;
    import fmbi_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    op;
    logic [RPM_W-1:0]        engine_rpm;
    logic signed [PRS_W-1:0] manifold_pressure;
    logic [IDX_W-1:0]        row_index;
    logic [IDX_W-1:0]        column_index;
    logic [15:0]             entry_value;

    modport source (
        output valid, op, engine_rpm, manifold_pressure, row_index, column_index,
               entry_value,
        input  ready
    );

    modport sink (
        input  valid, op, engine_rpm, manifold_pressure, row_index, column_index,
               entry_value,
        output ready
    );
endinterface

// File: src/fmbi_out_if.sv
`timescale 1ns / 1ps

interface fmbi_out_if;
    import fmbi_pkg::*;

    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] pulse_time;
    logic             clipped;

    modport source (
        output valid, pulse_time, clipped,
        input  ready
    );

    modport sink (
        input  valid, pulse_time, clipped,
        output ready
    );
endinterface

// File: src/fmbi_ram.sv
`timescale 1ns / 1ps

module fmbi_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

// File: src/fmbi_table.sv
`timescale 1ns / 1ps

module fmbi_table (
    input  logic               clk,
    input  fmbi_pkg::wr_req_t  wr,
    input  fmbi_pkg::rd_req_t  rd,
    output fmbi_pkg::corners_t corners
);
    import fmbi_pkg::*;

    localparam int BANK_AW = $clog2(BANK_DEPTH);

    // Entries are banked by row and column parity, so the four corners of any cell
    // always sit in four different banks and are read in the same cycle.
    logic [ENTRY_W-1:0] bank_q [0:BANK_N-1];
    logic               par_row_reg;
    logic               par_col_reg;

    genvar b;
    generate
        for (b = 0; b < BANK_N; b++)
        begin : g_bank
            localparam logic PR = 1'(b / 2);
            localparam logic PC = 1'(b % 2);

            logic [IDX_W-1:0]   row_sel;
            logic [IDX_W-1:0]   col_sel;
            logic [BANK_AW-1:0] rd_addr;
            logic [BANK_AW-1:0] wr_addr;
            logic               wr_en;

            always_comb
            begin
                row_sel = (rd.row[0] == PR) ? rd.row : rd.row + IDX_W'(1);
                col_sel = (rd.col[0] == PC) ? rd.col : rd.col + IDX_W'(1);
                rd_addr = {row_sel[IDX_W-1:1], col_sel[IDX_W-1:1]};
                wr_addr = {wr.row[IDX_W-1:1], wr.col[IDX_W-1:1]};
                wr_en   = wr.en && (wr.row[0] == PR) && (wr.col[0] == PC);
            end

            fmbi_ram #(
                .WIDTH (ENTRY_W),
                .DEPTH (BANK_DEPTH)
            ) u_ram (
                .clk     (clk),
                .wr_en   (wr_en),
                .wr_addr (wr_addr),
                .wr_data (wr.value),
                .rd_en   (rd.en),
                .rd_addr (rd_addr),
                .rd_data (bank_q[b])
            );
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            par_row_reg <= rd.row[0];
            par_col_reg <= rd.col[0];
        end
    end

    always_comb
    begin
        corners.t00 = bank_q[{par_row_reg, par_col_reg}];
        corners.t10 = bank_q[{~par_row_reg, par_col_reg}];
        corners.t01 = bank_q[{par_row_reg, ~par_col_reg}];
        corners.t11 = bank_q[{~par_row_reg, ~par_col_reg}];
    end
endmodule

// File: src/fuel_map_bilinear_interpolator.sv
`timescale 1ns / 1ps

// Channel    Side     Carries
// request    sink     op, engine_rpm, manifold_pressure, row_index, column_index, entry_value
// response   source   pulse_time, clipped
//
// One transfer per cycle on each channel while neither side stalls; a request passes through
// the pipeline stages in order (segment search and banked table read, reciprocal multiply,
// fraction, row blend, difference, split multiply, sum, round and saturate).
// Reset clears the stage valid bits only; table entries are undefined until written.
// A full stage holds only while the one after it is full and holding, so bubbles close up
// and requests keep flowing in while a finished response waits, until the stages fill.

module fuel_map_bilinear_interpolator (
    input  logic       clk,
    input  logic       rst_n,
    fmbi_in_if.sink    request,
    fmbi_out_if.source response
);
    import fmbi_pkg::*;

    logic [PIPE_DEPTH+1:1] en;
    logic [PIPE_DEPTH:1]   valid_reg;
    logic [PIPE_DEPTH:1]   valid_next;
    logic [PIPE_DEPTH:1]   op_reg;
    logic [PIPE_DEPTH:1]   op_next;

    logic [BRK_N-1:0]      spd_above;
    logic [BRK_N-1:0]      prs_below;
    logic [IDX_W-1:0]      seg_i;
    logic [IDX_W-1:0]      seg_j;
    wr_req_t               wr;
    rd_req_t               rd;
    corners_t              corners;

    logic [IDX_W-1:0]          s1_i_reg;
    logic [IDX_W-1:0]          s1_j_reg;
    logic [RPM_W-1:0]          s1_rpm_reg;
    logic signed [PRS_W-1:0]   s1_prs_reg;

    logic signed [15:0]        x_diff;
    logic signed [12:0]        y_diff;
    logic [XU_W-1:0]           xu;
    logic [YU_W-1:0]           yu;
    logic [XPROD_W-1:0]        s2_xprod_next;
    logic [YPROD_W-1:0]        s2_yprod_next;
    logic signed [DIFF_W-1:0]  s2_da_next;
    logic signed [DIFF_W-1:0]  s2_db_next;
    logic [XPROD_W-1:0]        s2_xprod_reg;
    logic [YPROD_W-1:0]        s2_yprod_reg;
    logic                      s2_xseg0_reg;
    logic                      s2_yseg0_reg;
    logic [ENTRY_W-1:0]        s2_t00_reg;
    logic [ENTRY_W-1:0]        s2_t01_reg;
    logic signed [DIFF_W-1:0]  s2_da_reg;
    logic signed [DIFF_W-1:0]  s2_db_reg;

    logic signed [FRAC_W-1:0]  s3_fr_next;
    logic signed [FRAC_W-1:0]  s3_fm_next;
    logic signed [FRAC_W-1:0]  s3_fr_reg;
    logic signed [FRAC_W-1:0]  s3_fm_reg;
    logic [ENTRY_W-1:0]        s3_t00_reg;
    logic [ENTRY_W-1:0]        s3_t01_reg;
    logic signed [DIFF_W-1:0]  s3_da_reg;
    logic signed [DIFF_W-1:0]  s3_db_reg;

    logic signed [FRAC_W+DIFF_W-1:0] prod_a;
    logic signed [FRAC_W+DIFF_W-1:0] prod_b;
    logic signed [ACC_W-1:0]   s4_a_next;
    logic signed [ACC_W-1:0]   s4_b_next;
    logic signed [ACC_W-1:0]   s4_a_reg;
    logic signed [ACC_W-1:0]   s4_b_reg;
    logic signed [FRAC_W-1:0]  s4_fm_reg;

    logic signed [ACC_W-1:0]   s5_d_next;
    logic signed [ACC_W-1:0]   s5_a_reg;
    logic signed [ACC_W-1:0]   s5_d_reg;
    logic signed [FRAC_W-1:0]  s5_fm_reg;

    logic signed [LO_W:0]          d_lo;
    logic signed [HI_W-1:0]        d_hi;
    logic signed [FRAC_W+LO_W:0]   s6_plo_next;
    logic signed [FRAC_W+HI_W-1:0] s6_phi_next;
    logic signed [ACC_W-1:0]       s6_a_reg;
    logic signed [FRAC_W+LO_W:0]   s6_plo_reg;
    logic signed [FRAC_W+HI_W-1:0] s6_phi_reg;

    logic signed [SUM_W-1:0]   s7_sum_next;
    logic signed [SUM_W-1:0]   s7_sum_reg;

    logic signed [RND_W-1:0]   rnd;
    logic [OUT_W-1:0]          pulse_time_next;
    logic                      clipped_next;
    logic [OUT_W-1:0]          pulse_time_reg;
    logic                      clipped_reg;

    always_comb
    begin
        en[PIPE_DEPTH+1] = response.ready;
        for (int k = PIPE_DEPTH; k >= 1; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    always_comb
    begin
        valid_next = (en[PIPE_DEPTH:1] & {valid_reg[PIPE_DEPTH-1:1], request.valid})
                   | (~en[PIPE_DEPTH:1] & valid_reg);
        op_next    = (en[PIPE_DEPTH:1] & {op_reg[PIPE_DEPTH-1:1], request.op})
                   | (~en[PIPE_DEPTH:1] & op_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
    end

    // Segment search: the segment index is the number of inner breakpoints passed.
    always_comb
    begin
        for (int k = 0; k < BRK_N; k++)
        begin
            spd_above[k] = request.engine_rpm > SPD_BRK[k];
            prs_below[k] = request.manifold_pressure < PRS_BRK[k];
        end
        seg_i = IDX_W'($countones(spd_above));
        seg_j = IDX_W'($countones(prs_below));
    end

    always_comb
    begin
        wr.en    = request.valid && en[1] && (request.op == OP_WRITE);
        wr.row   = request.row_index;
        wr.col   = request.column_index;
        wr.value = request.entry_value[ENTRY_W-1:0];
        rd.en    = en[1];
        rd.row   = seg_i;
        rd.col   = seg_j;
    end

    fmbi_table u_table (
        .clk     (clk),
        .wr      (wr),
        .rd      (rd),
        .corners (corners)
    );

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s1_i_reg   <= seg_i;
            s1_j_reg   <= seg_j;
            s1_rpm_reg <= request.engine_rpm;
            s1_prs_reg <= request.manifold_pressure;
        end
    end

    // Fractions are floor(u * 2^16 / d), taken as u times a rounded-up reciprocal of d.
    always_comb
    begin
        x_diff        = $signed({2'b00, s1_rpm_reg}) - SPD_BASE[s1_i_reg];
        y_diff        = PRS_BASE[s1_j_reg] - $signed({{2{s1_prs_reg[PRS_W-1]}}, s1_prs_reg});
        xu            = x_diff[XU_W-1:0];
        yu            = y_diff[YU_W-1:0];
        s2_xprod_next = XPROD_W'(xu) * XPROD_W'(SPD_RECIP[s1_i_reg]);
        s2_yprod_next = YPROD_W'(yu) * YPROD_W'(PRS_RECIP[s1_j_reg]);
        s2_da_next    = $signed({1'b0, corners.t10}) - $signed({1'b0, corners.t00});
        s2_db_next    = $signed({1'b0, corners.t11}) - $signed({1'b0, corners.t01});
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s2_xprod_reg <= s2_xprod_next;
            s2_yprod_reg <= s2_yprod_next;
            s2_xseg0_reg <= (s1_i_reg == '0);
            s2_yseg0_reg <= (s1_j_reg == '0);
            s2_t00_reg   <= corners.t00;
            s2_t01_reg   <= corners.t01;
            s2_da_reg    <= s2_da_next;
            s2_db_reg    <= s2_db_next;
        end
    end

    always_comb
    begin
        s3_fr_next = $signed({1'b0, s2_xprod_reg[Q_SHIFT +: Q_W]})
                   - (s2_xseg0_reg ? SPD_SEG0_OFS : '0);
        s3_fm_next = $signed({1'b0, s2_yprod_reg[Q_SHIFT +: Q_W]})
                   - (s2_yseg0_reg ? PRS_SEG0_OFS : '0);
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s3_fr_reg  <= s3_fr_next;
            s3_fm_reg  <= s3_fm_next;
            s3_t00_reg <= s2_t00_reg;
            s3_t01_reg <= s2_t01_reg;
            s3_da_reg  <= s2_da_reg;
            s3_db_reg  <= s2_db_reg;
        end
    end

    always_comb
    begin
        prod_a    = s3_fr_reg * s3_da_reg;
        prod_b    = s3_fr_reg * s3_db_reg;
        s4_a_next = $signed(ACC_W'({s3_t00_reg, {FRAC_BITS{1'b0}}})) + ACC_W'(prod_a);
        s4_b_next = $signed(ACC_W'({s3_t01_reg, {FRAC_BITS{1'b0}}})) + ACC_W'(prod_b);
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s4_a_reg  <= s4_a_next;
            s4_b_reg  <= s4_b_next;
            s4_fm_reg <= s3_fm_reg;
        end
    end

    assign s5_d_next = s4_b_reg - s4_a_reg;

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            s5_a_reg  <= s4_a_reg;
            s5_d_reg  <= s5_d_next;
            s5_fm_reg <= s4_fm_reg;
        end
    end

    // The wide difference is multiplied in two halves, summed in the next stage.
    always_comb
    begin
        d_lo        = $signed({1'b0, s5_d_reg[LO_W-1:0]});
        d_hi        = s5_d_reg[ACC_W-1:LO_W];
        s6_plo_next = s5_fm_reg * d_lo;
        s6_phi_next = s5_fm_reg * d_hi;
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            s6_a_reg   <= s5_a_reg;
            s6_plo_reg <= s6_plo_next;
            s6_phi_reg <= s6_phi_next;
        end
    end

    always_comb
    begin
        s7_sum_next = (SUM_W'(s6_a_reg) <<< FRAC_BITS)
                    + (SUM_W'(s6_phi_reg) <<< LO_W)
                    + SUM_W'(s6_plo_reg)
                    + (SUM_W'(1) <<< (2 * FRAC_BITS - 1));
    end

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            s7_sum_reg <= s7_sum_next;
        end
    end

    always_comb
    begin
        rnd = s7_sum_reg[SUM_W-1:2*FRAC_BITS];
        if (op_reg[7] == OP_WRITE)
        begin
            pulse_time_next = '0;
            clipped_next    = 1'b0;
        end
        else if (rnd[RND_W-1])
        begin
            pulse_time_next = '0;
            clipped_next    = 1'b1;
        end
        else if (|rnd[RND_W-2:OUT_W])
        begin
            pulse_time_next = '1;
            clipped_next    = 1'b1;
        end
        else
        begin
            pulse_time_next = rnd[OUT_W-1:0];
            clipped_next    = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[8])
        begin
            pulse_time_reg <= pulse_time_next;
            clipped_reg    <= clipped_next;
        end
    end

    assign request.ready       = en[1];
    assign response.valid      = valid_reg[PIPE_DEPTH];
    assign response.pulse_time = pulse_time_reg;
    assign response.clipped    = clipped_reg;
endmodule

// File: src/fmbi_checker.sv
`timescale 1ns / 1ps

module fmbi_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       req_valid,
    input logic                       req_ready,
    input logic                       rsp_valid,
    input logic                       rsp_ready,
    input logic [fmbi_pkg::OUT_W-1:0] pulse_time,
    input logic                       clipped
);
    import fmbi_pkg::*;

    localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

    // Number of requests taken whose responses have not yet been transferred.
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign count_next = count_reg + CNT_W'(req_valid && req_ready)
                                  - CNT_W'(rsp_valid && rsp_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(pulse_time) && $stable(clipped))
        else $error("response changed while stalled");

    a_clip_edge: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && clipped |-> (pulse_time == '0) || (pulse_time == '1))
        else $error("clipped response not at a rail");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> count_reg != '0)
        else $error("response without a pending request");

    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> req_ready)
        else $error("empty pipeline refused a request");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(PIPE_DEPTH))
        else $error("more requests in flight than pipeline stages");
endmodule

bind fuel_map_bilinear_interpolator fmbi_checker u_fmbi_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (request.valid),
    .req_ready  (request.ready),
    .rsp_valid  (response.valid),
    .rsp_ready  (response.ready),
    .pulse_time (response.pulse_time),
    .clipped    (response.clipped)
);
